FILE: src/sms_pkg.sv
// Shared types, constants and helpers for the shared-pool multi-stack.
package sms_pkg;

    localparam int POOL_DEPTH = 64;
    localparam int NUM_STACKS = 4;
    localparam int ADDR_W     = $clog2(POOL_DEPTH);
    localparam int PTR_W      = ADDR_W + 1;
    localparam int DATA_W     = 32;
    localparam int STACK_W    = 2;
    localparam int STATUS_W   = 2;

    localparam logic [PTR_W-1:0] PTR_NULL = PTR_W'(POOL_DEPTH);

    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_POP  = 1'b1;

    localparam logic [STATUS_W-1:0] STATUS_DONE  = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

    typedef struct packed {
        logic                       operation;
        logic [STACK_W-1:0]         stack_index;
        logic signed [DATA_W-1:0]   push_value;
    } req_t;

    typedef struct packed {
        logic [STATUS_W-1:0]        status;
        logic signed [DATA_W-1:0]   pop_value;
    } rsp_t;

    typedef struct packed {
        logic                       en;
        logic                       data_en;
        logic [ADDR_W-1:0]          addr;
        logic [PTR_W-1:0]           link;
        logic [DATA_W-1:0]          data;
    } pool_wr_t;

    function automatic logic ptr_ok(input logic [PTR_W-1:0] p);
        return p < PTR_W'(POOL_DEPTH);
    endfunction

    function automatic logic stack_ok(input logic [STACK_W-1:0] s);
        return 32'(s) < NUM_STACKS;
    endfunction

endpackage

FILE: src/shared_pool_multi_stack_top.sv
// Top level of the shared-pool multi-stack: control, stack tops and free list head.
//
//  channel  | signals                        | moves
//  ---------+--------------------------------+-----------------------------------
//  request  | req_valid, req_ready, req      | push/pop item for one stack
//  response | rsp_valid, rsp_ready, rsp      | status and popped value per item
//
// For each item, the accept edge reads the pool memories at the
// free head or the stack top; a later edge writes back and loads the result, once
// any held result is taken. A new item is taken only after the last one completes.
// Reset empties every stack and chains all entries into the free list at once.
// A held result stalls completion of the following item, not its acceptance.
module shared_pool_multi_stack_top (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    output logic            req_ready,
    input  sms_pkg::req_t   req,
    output logic            rsp_valid,
    input  logic            rsp_ready,
    output sms_pkg::rsp_t   rsp
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EXEC = 2'b10
    } state_t;

    state_t                     state_reg, state_next;
    sms_pkg::req_t              req_reg;
    logic [sms_pkg::PTR_W-1:0]  top_sel_reg;
    logic [sms_pkg::PTR_W-1:0]  top_reg [sms_pkg::NUM_STACKS];
    logic [sms_pkg::PTR_W-1:0]  free_head_reg;
    logic                       rsp_valid_reg;
    sms_pkg::rsp_t              rsp_reg, rsp_next;

    logic                       accept;
    logic                       exec_done;
    logic                       is_push;
    logic                       ok;
    logic [sms_pkg::PTR_W-1:0]  top_lookup;
    logic [sms_pkg::PTR_W-1:0]  slot;
    logic [sms_pkg::ADDR_W-1:0] rd_addr;
    logic [sms_pkg::PTR_W-1:0]  link_q;
    logic [sms_pkg::DATA_W-1:0] data_q;
    sms_pkg::pool_wr_t          wr;

    sms_pool u_pool (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (accept),
        .rd_addr (rd_addr),
        .wr      (wr),
        .link_q  (link_q),
        .data_q  (data_q)
    );

    assign req_ready = (state_reg == ST_IDLE);
    assign accept    = req_valid && req_ready;
    assign exec_done = (state_reg == ST_EXEC) && (!rsp_valid_reg || rsp_ready);

    assign top_lookup = sms_pkg::stack_ok(req.stack_index) ? top_reg[req.stack_index]
                      : sms_pkg::PTR_NULL;
    assign rd_addr    = (req.operation == sms_pkg::OP_PUSH)
                      ? free_head_reg[sms_pkg::ADDR_W-1:0]
                      : top_lookup[sms_pkg::ADDR_W-1:0];

    assign is_push = (req_reg.operation == sms_pkg::OP_PUSH);
    assign slot    = is_push ? free_head_reg : top_sel_reg;
    assign ok      = sms_pkg::stack_ok(req_reg.stack_index) && sms_pkg::ptr_ok(slot);

    always_comb
    begin
        wr.en      = exec_done && ok;
        wr.data_en = is_push;
        wr.addr    = slot[sms_pkg::ADDR_W-1:0];
        wr.link    = is_push ? top_sel_reg : free_head_reg;
        wr.data    = req_reg.push_value;

        rsp_next.status    = ok ? sms_pkg::STATUS_DONE
                           : (is_push ? sms_pkg::STATUS_FULL : sms_pkg::STATUS_EMPTY);
        rsp_next.pop_value = (ok && !is_push) ? data_q : '0;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (exec_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            free_head_reg <= '0;
            rsp_valid_reg <= 1'b0;
            for (int i = 0; i < sms_pkg::NUM_STACKS; i++)
            begin
                top_reg[i] <= sms_pkg::PTR_NULL;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (wr.en)
            begin
                top_reg[req_reg.stack_index] <= is_push ? slot : link_q;
                free_head_reg                <= is_push ? link_q : slot;
            end
            if (exec_done)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg     <= req;
            top_sel_reg <= top_lookup;
        end
        if (exec_done)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

FILE: src/sms_pool.sv
// Entry pool: link and data memories with registered read and link reset tracking.
module sms_pool (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            rd_en,
    input  logic [sms_pkg::ADDR_W-1:0]      rd_addr,
    input  sms_pkg::pool_wr_t               wr,
    output logic [sms_pkg::PTR_W-1:0]       link_q,
    output logic [sms_pkg::DATA_W-1:0]      data_q
);

    logic [sms_pkg::PTR_W-1:0]      link_mem [sms_pkg::POOL_DEPTH];
    logic [sms_pkg::DATA_W-1:0]     data_mem [sms_pkg::POOL_DEPTH];
    logic [sms_pkg::POOL_DEPTH-1:0] written_reg;
    logic [sms_pkg::ADDR_W-1:0]     rd_addr_reg;
    logic [sms_pkg::PTR_W-1:0]      link_rd_reg;
    logic [sms_pkg::DATA_W-1:0]     data_rd_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            link_mem[wr.addr] <= wr.link;
        end
        if (rd_en)
        begin
            link_rd_reg <= link_mem[rd_addr];
            rd_addr_reg <= rd_addr;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr.en && wr.data_en)
        begin
            data_mem[wr.addr] <= wr.data;
        end
        if (rd_en)
        begin
            data_rd_reg <= data_mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            written_reg <= '0;
        end
        else if (wr.en)
        begin
            written_reg[wr.addr] <= 1'b1;
        end
    end

    // unwritten link entries point to the next entry; the last one is null
    assign link_q = written_reg[rd_addr_reg] ? link_rd_reg
                  : ({1'b0, rd_addr_reg} + sms_pkg::PTR_W'(1));
    assign data_q = data_rd_reg;

endmodule

FILE: sim/stack_response_checker.sv
// Checker for the shared-pool multi-stack: tracks pool state, predicts each response and compares.
`timescale 1ns / 100ps

module stack_response_checker (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    input  logic           req_ready,
    input  sms_pkg::req_t  req,
    input  logic           rsp_valid,
    input  logic           rsp_ready,
    input  sms_pkg::rsp_t  rsp,
    output int             fail_count,
    output int             outstanding
);

    logic signed [sms_pkg::DATA_W-1:0] pool_data [sms_pkg::POOL_DEPTH];
    logic [sms_pkg::PTR_W-1:0]         pool_link [sms_pkg::POOL_DEPTH];
    logic [sms_pkg::PTR_W-1:0]         stack_top [sms_pkg::NUM_STACKS];
    logic [sms_pkg::PTR_W-1:0]         free_head;

    sms_pkg::rsp_t expected_responses[$];
    int            mismatches;

    function automatic logic slot_valid(input logic [sms_pkg::PTR_W-1:0] p);
        return p < sms_pkg::PTR_W'(sms_pkg::POOL_DEPTH);
    endfunction

    // Applies one push or pop to the tracked pool and returns its response.
    function automatic sms_pkg::rsp_t apply_request(input sms_pkg::req_t r);
        sms_pkg::rsp_t                 res;
        logic [sms_pkg::PTR_W-1:0]     slot;
        logic [sms_pkg::ADDR_W-1:0]    addr;
        int                            s;
        res.status    = sms_pkg::STATUS_DONE;
        res.pop_value = '0;
        s = int'(r.stack_index);
        if (r.operation == sms_pkg::OP_PUSH)
        begin
            slot = free_head;
            if (s >= sms_pkg::NUM_STACKS || !slot_valid(slot))
            begin
                res.status = sms_pkg::STATUS_FULL;
            end
            else
            begin
                addr            = slot[sms_pkg::ADDR_W-1:0];
                free_head       = pool_link[addr];
                pool_data[addr] = r.push_value;
                pool_link[addr] = stack_top[s];
                stack_top[s]    = slot;
            end
        end
        else
        begin
            if (s >= sms_pkg::NUM_STACKS || !slot_valid(stack_top[s]))
            begin
                res.status = sms_pkg::STATUS_EMPTY;
            end
            else
            begin
                slot            = stack_top[s];
                addr            = slot[sms_pkg::ADDR_W-1:0];
                stack_top[s]    = pool_link[addr];
                pool_link[addr] = free_head;
                free_head       = slot;
                res.pop_value   = pool_data[addr];
            end
        end
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        sms_pkg::rsp_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < sms_pkg::POOL_DEPTH; i++)
            begin
                pool_data[i] = '0;
                pool_link[i] = sms_pkg::PTR_W'(i + 1);
            end
            pool_link[sms_pkg::POOL_DEPTH-1] = sms_pkg::PTR_NULL;
            for (int i = 0; i < sms_pkg::NUM_STACKS; i++)
            begin
                stack_top[i] = sms_pkg::PTR_NULL;
            end
            free_head = '0;
            expected_responses.delete();
            mismatches  = 0;
            fail_count  <= 0;
            outstanding <= 0;
        end
        else
        begin
            // response first: it belongs to an item taken at an earlier edge
            if (rsp_valid && rsp_ready)
            begin
                if (expected_responses.size() == 0)
                begin
                    $error("response with no item pending: status %0d, pop_value %0d",
                           rsp.status, rsp.pop_value);
                    mismatches++;
                end
                else
                begin
                    want = expected_responses.pop_front();
                    if (rsp.status !== want.status)
                    begin
                        $error("status: expected %0d, actual %0d", want.status, rsp.status);
                        mismatches++;
                    end
                    if (rsp.pop_value !== want.pop_value)
                    begin
                        $error("pop_value: expected %0d, actual %0d",
                               want.pop_value, rsp.pop_value);
                        mismatches++;
                    end
                end
            end
            if (req_valid && req_ready)
            begin
                expected_responses.push_back(apply_request(req));
            end
            fail_count  <= mismatches;
            outstanding <= expected_responses.size();
        end
    end

endmodule

FILE: sim/tb.sv
// Testbench top for the shared-pool multi-stack: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module tb;

    localparam int RANDOM_ITEMS = 1200;
    localparam int HOLD_CYCLES  = 300;

    logic          clk;
    logic          rst_n;
    logic          req_valid;
    logic          req_ready;
    sms_pkg::req_t req;
    logic          rsp_valid;
    logic          rsp_ready = 1'b0;
    sms_pkg::rsp_t rsp;

    int fail_count;
    int outstanding;

    int tx_idle_pct = 37;
    int rx_idle_pct = 62;
    int hold_requests = 0;
    int hold_seen;
    int hold_left;

    shared_pool_multi_stack_top u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    stack_response_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_ready   (req_ready),
        .req         (req),
        .rsp_valid   (rsp_valid),
        .rsp_ready   (rsp_ready),
        .rsp         (rsp),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("status: fail");
        $finish;
    end

    // response side: random stalls, plus a long hold when asked
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_ready <= 1'b0;
            hold_seen = 0;
            hold_left = 0;
        end
        else if (hold_seen != hold_requests)
        begin
            hold_seen = hold_requests;
            hold_left = HOLD_CYCLES;
            rsp_ready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left--;
            rsp_ready <= 1'b0;
        end
        else
        begin
            rsp_ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    function automatic sms_pkg::req_t make_req(input logic op,
                                               input logic [sms_pkg::STACK_W-1:0] s,
                                               input logic [sms_pkg::DATA_W-1:0] v);
        sms_pkg::req_t r;
        r.operation   = op;
        r.stack_index = s;
        r.push_value  = v;
        return r;
    endfunction

    // returns at the edge that accepts the item
    task automatic send_item(input sms_pkg::req_t item);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req       <= item;
        do @(posedge clk); while (!req_ready);
    endtask

    task automatic drain_responses();
        req_valid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
    endtask

    initial
    begin
        int sent;
        int run_len;
        int push_pct;
        int focus;
        logic [sms_pkg::STACK_W-1:0] run_stack;
        logic op;

        rst_n     = 1'b0;
        req_valid = 1'b0;
        req       = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty stacks, extreme values, ignored value on pop
        for (int i = 0; i < sms_pkg::NUM_STACKS; i++)
        begin
            send_item(make_req(sms_pkg::OP_POP, sms_pkg::STACK_W'(i), 32'hFFFF_FFFF));
        end
        send_item(make_req(sms_pkg::OP_PUSH, 2'd0, 32'h7FFF_FFFF));
        send_item(make_req(sms_pkg::OP_PUSH, 2'd1, 32'h8000_0000));
        send_item(make_req(sms_pkg::OP_PUSH, 2'd2, 32'h0000_0000));
        send_item(make_req(sms_pkg::OP_PUSH, 2'd3, 32'hFFFF_FFFF));
        send_item(make_req(sms_pkg::OP_PUSH, 2'd0, 32'h5555_AAAA));
        send_item(make_req(sms_pkg::OP_POP,  2'd0, 32'h1234_5678));
        send_item(make_req(sms_pkg::OP_POP,  2'd0, 32'h0000_0000));
        send_item(make_req(sms_pkg::OP_POP,  2'd0, 32'h0000_0000));
        send_item(make_req(sms_pkg::OP_POP,  2'd1, 32'h0000_0000));
        send_item(make_req(sms_pkg::OP_POP,  2'd2, 32'h0000_0000));
        send_item(make_req(sms_pkg::OP_POP,  2'd3, 32'h0000_0000));
        send_item(make_req(sms_pkg::OP_POP,  2'd1, 32'h0000_0000));
        send_item(make_req(sms_pkg::OP_PUSH, 2'd3, 32'hAAAA_5555));
        send_item(make_req(sms_pkg::OP_PUSH, 2'd3, 32'h0000_0001));
        send_item(make_req(sms_pkg::OP_POP,  2'd3, 32'h0000_0000));
        send_item(make_req(sms_pkg::OP_POP,  2'd3, 32'h0000_0000));

        // random runs: push-heavy runs fill the pool, pop-heavy runs drain stacks
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            run_len = $urandom_range(120, 20);
            case ($urandom_range(3))
                0:       push_pct = 92;
                1:       push_pct = 50;
                2:       push_pct = 8;
                default: push_pct = $urandom_range(100);
            endcase
            focus     = $urandom_range(1);
            run_stack = sms_pkg::STACK_W'($urandom_range(sms_pkg::NUM_STACKS - 1));
            for (int k = 0; k < run_len && sent < RANDOM_ITEMS; k++)
            begin
                if (sent < RANDOM_ITEMS / 3)
                begin
                    tx_idle_pct = 37;
                    rx_idle_pct = 62;
                end
                else if (sent < 2 * RANDOM_ITEMS / 3)
                begin
                    tx_idle_pct = 62;
                    rx_idle_pct = 37;
                end
                else
                begin
                    tx_idle_pct = 0;
                    rx_idle_pct = 0;
                end
                if (sent == 100 || sent == 900)
                begin
                    hold_requests++;
                end
                if (sent == 600)
                begin
                    drain_responses();
                end
                op = ($urandom_range(99) < push_pct) ? sms_pkg::OP_PUSH : sms_pkg::OP_POP;
                send_item(make_req(op,
                                   focus ? run_stack
                                         : sms_pkg::STACK_W'(
                                               $urandom_range(sms_pkg::NUM_STACKS - 1)),
                                   $urandom()));
                sent++;
            end
        end

        drain_responses();
        repeat (16) @(posedge clk);
        if (fail_count == 0 && outstanding == 0)
        begin
            $display("status: pass");
        end
        else
        begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
